// File: rtl/text_cell_markup_writer_assert.svh
// Assertion macros for the text cell writer.
// Included by the top level; the assertions use the caller's i_clk and i_rst_n.
`ifndef TEXT_CELL_MARKUP_WRITER_ASSERT_SVH
`define TEXT_CELL_MARKUP_WRITER_ASSERT_SVH
`ifndef SYNTH
`define TCMW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TCMW_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define TCMW_ASSERT(lbl, prop, msg)
`define TCMW_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/tcmw_pkg.sv
// Shared types and constants for the text cell writer.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
`default_nettype none
package tcmw_pkg;

    // Number of cells in the display buffer.
    localparam int CELLS = 160;

    // Width of row * columns + column before truncation.
    localparam int IDX_W = 17;

    // APB address width: five 32-bit registers.
    localparam int ADDR_W = 5;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_RBR = 8'h5D;

    localparam logic [7:0] COLUMNS_RST = 8'd16;
    localparam logic [7:0] ROWS_RST    = 8'd10;

    typedef enum logic [2:0] {
        REG_COLUMNS    = 3'd0,
        REG_ROWS       = 3'd1,
        REG_NORMAL_FG  = 3'd2,
        REG_SPECIAL_FG = 3'd3,
        REG_NORMAL_BG  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  columns;
        logic [7:0]  rows;
        logic [15:0] normal_fg;
        logic [15:0] special_fg;
        logic [15:0] normal_bg;
    } t_cfg;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       append_line;
        logic [7:0] start_col;
        logic [7:0] start_row;
    } t_item;

    typedef struct packed {
        logic        write_en;
        logic [7:0]  cell_index;
        logic [7:0]  cell_char;
        logic [15:0] cell_fg;
        logic [15:0] cell_bg;
        logic        string_done;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/tcmw_cfg_regs.sv
// APB register file for the text cell writer: grid size and colours.
// Depends on tcmw_pkg.
`default_nettype none
module tcmw_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcmw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output tcmw_pkg::t_cfg                   o_cfg
);

    tcmw_pkg::t_cfg   r_cfg;
    tcmw_pkg::t_reg_idx reg_sel;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_sel = tcmw_pkg::t_reg_idx'(paddr[tcmw_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns    <= tcmw_pkg::COLUMNS_RST;
            r_cfg.rows       <= tcmw_pkg::ROWS_RST;
            r_cfg.normal_fg  <= 16'd0;
            r_cfg.special_fg <= 16'd0;
            r_cfg.normal_bg  <= 16'd0;
        end else if (wr_en) begin
            unique case (reg_sel)
                tcmw_pkg::REG_COLUMNS:    r_cfg.columns    <= pwdata[7:0];
                tcmw_pkg::REG_ROWS:       r_cfg.rows       <= pwdata[7:0];
                tcmw_pkg::REG_NORMAL_FG:  r_cfg.normal_fg  <= pwdata[15:0];
                tcmw_pkg::REG_SPECIAL_FG: r_cfg.special_fg <= pwdata[15:0];
                tcmw_pkg::REG_NORMAL_BG:  r_cfg.normal_bg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            tcmw_pkg::REG_COLUMNS:    prdata = {24'd0, r_cfg.columns};
            tcmw_pkg::REG_ROWS:       prdata = {24'd0, r_cfg.rows};
            tcmw_pkg::REG_NORMAL_FG:  prdata = {16'd0, r_cfg.normal_fg};
            tcmw_pkg::REG_SPECIAL_FG: prdata = {16'd0, r_cfg.special_fg};
            tcmw_pkg::REG_NORMAL_BG:  prdata = {16'd0, r_cfg.normal_bg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: rtl/tcmw_in_stage.sv
// Input register of the text cell writer: holds one character word.
// Depends on tcmw_pkg.
`default_nettype none
module tcmw_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire tcmw_pkg::t_item i_item,
    output logic                 o_stall,
    input  wire logic            i_take,
    output logic                 o_valid,
    output tcmw_pkg::t_item      o_item
);

    logic            r_valid;
    tcmw_pkg::t_item r_item;
    logic            accept;

    // The register frees up in the same cycle its word moves on.
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// File: rtl/tcmw_cursor.sv
// Cursor state and per-character decision of the text cell writer.
// Depends on tcmw_pkg; the state advances only when i_fire is high.
`default_nettype none
module tcmw_cursor (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire tcmw_pkg::t_item i_item,
    input  wire tcmw_pkg::t_cfg  i_cfg,
    output tcmw_pkg::t_result    o_res
);

    logic [7:0] r_cur_row, n_cur_row;
    logic [7:0] r_cur_col, n_cur_col;
    logic [7:0] r_home_col, n_home_col;
    logic [7:0] r_line_counter, n_line_counter;
    logic       r_special_on, n_special_on;
    logic       r_accepting, n_accepting;
    logic       r_append_active, n_append_active;

    logic [7:0]                 row_a;
    logic [7:0]                 col_a;
    logic [7:0]                 lc_inc;
    logic [15:0]                row_base;
    logic [tcmw_pkg::IDX_W-1:0] idx;
    tcmw_pkg::t_result          res;

    always_comb begin
        n_cur_row       = r_cur_row;
        n_cur_col       = r_cur_col;
        n_home_col      = r_home_col;
        n_line_counter  = r_line_counter;
        n_special_on    = r_special_on;
        n_accepting     = r_accepting;
        n_append_active = r_append_active;
        res             = '0;
        row_a           = 8'd0;
        col_a           = 8'd0;
        row_base        = 16'd0;
        idx             = '0;
        lc_inc          = r_line_counter + 8'd1;

        // A new string drops whatever string was active before it.
        if (i_item.first) begin
            n_special_on = 1'b0;
            if (i_item.append_line) begin
                n_accepting     = 1'b1;
                n_append_active = 1'b1;
                n_cur_row       = r_line_counter;
                n_cur_col       = 8'd0;
                n_home_col      = 8'd0;
            end else if (i_item.start_col < i_cfg.columns &&
                         i_item.start_row < i_cfg.rows) begin
                n_accepting     = 1'b1;
                n_append_active = 1'b0;
                n_cur_row       = i_item.start_row;
                n_cur_col       = i_item.start_col;
                n_home_col      = i_item.start_col;
            end else begin
                n_accepting     = 1'b0;
                n_append_active = 1'b0;
            end
        end

        if (n_accepting) begin
            if (i_item.ch == tcmw_pkg::CH_NUL) begin
                res.string_done = 1'b1;
                if (n_append_active) begin
                    n_line_counter = (lc_inc >= i_cfg.rows) ? 8'd0 : lc_inc;
                end
                n_accepting     = 1'b0;
                n_append_active = 1'b0;
            end else begin
                row_a = n_cur_row;
                col_a = n_cur_col;
                // A column left past the row end wraps before the write.
                if (col_a >= i_cfg.columns) begin
                    col_a = 8'd0;
                    if (row_a < i_cfg.rows) begin
                        row_a = row_a + 8'd1;
                    end
                end
                n_cur_row = row_a;
                n_cur_col = col_a;
                row_base  = 16'(row_a) * 16'(i_cfg.columns);
                idx       = {1'b0, row_base} + tcmw_pkg::IDX_W'(col_a);
                if (row_a < i_cfg.rows && idx < tcmw_pkg::IDX_W'(tcmw_pkg::CELLS)) begin
                    priority if (i_item.ch == tcmw_pkg::CH_CR ||
                                 i_item.ch == tcmw_pkg::CH_LF) begin
                        if (row_a < i_cfg.rows) begin
                            n_cur_row = row_a + 8'd1;
                        end
                        n_cur_col = n_home_col;
                    end else if (i_item.ch == tcmw_pkg::CH_LBR) begin
                        n_special_on = 1'b1;
                    end else if (i_item.ch == tcmw_pkg::CH_RBR) begin
                        n_special_on = 1'b0;
                    end else begin
                        res.write_en   = 1'b1;
                        res.cell_index = idx[7:0];
                        res.cell_char  = i_item.ch;
                        res.cell_fg    = n_special_on ? i_cfg.special_fg : i_cfg.normal_fg;
                        res.cell_bg    = i_cfg.normal_bg;
                        if (col_a + 8'd1 >= i_cfg.columns) begin
                            n_cur_col = 8'd0;
                            n_cur_row = row_a + 8'd1;
                        end else begin
                            n_cur_col = col_a + 8'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row       <= 8'd0;
            r_cur_col       <= 8'd0;
            r_home_col      <= 8'd0;
            r_line_counter  <= 8'd0;
            r_special_on    <= 1'b0;
            r_accepting     <= 1'b0;
            r_append_active <= 1'b0;
        end else if (i_fire) begin
            r_cur_row       <= n_cur_row;
            r_cur_col       <= n_cur_col;
            r_home_col      <= n_home_col;
            r_line_counter  <= n_line_counter;
            r_special_on    <= n_special_on;
            r_accepting     <= n_accepting;
            r_append_active <= n_append_active;
        end
    end

    assign o_res = res;

endmodule
`default_nettype wire

// File: rtl/tcmw_out_stage.sv
// Result register of the text cell writer with its valid/stall handshake.
// Depends on tcmw_pkg.
`default_nettype none
module tcmw_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire tcmw_pkg::t_result i_res,
    output logic                   o_take,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output tcmw_pkg::t_result      o_res
);

    logic              r_valid;
    tcmw_pkg::t_result r_res;

    // A new word loads when the register is empty or its word leaves now.
    assign o_take = i_valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= o_take || (r_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// File: rtl/text_cell_markup_writer.sv
// Top level of the text cell writer: register file, input register, cursor, result register.
// Depends on tcmw_pkg, tcmw_cfg_regs, tcmw_in_stage, tcmw_cursor, tcmw_out_stage.
`default_nettype none
`include "text_cell_markup_writer_assert.svh"
// Takes one string character word per cycle while the input is not stalled
// and returns one result word per character. The character sits in an input
// register, the cursor logic decides the cell write, and the result is
// loaded into an output register when that register is empty or its word
// leaves. The input register frees up in the same cycle its word moves to
// the output, so back-to-back characters run at one per cycle while the
// output is not stalled. The cell index is row times columns plus column,
// formed by one 8 by 8 multiplier in the cursor logic. Write the registers
// only while no character is in flight.
module text_cell_markup_writer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcmw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_ch,
    input  wire logic                        i_first,
    input  wire logic                        i_append_line,
    input  wire logic [7:0]                  i_start_col,
    input  wire logic [7:0]                  i_start_row,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_write_en,
    output logic      [7:0]                  o_cell_index,
    output logic      [7:0]                  o_cell_char,
    output logic      [15:0]                 o_cell_fg,
    output logic      [15:0]                 o_cell_bg,
    output logic                             o_string_done
);

    tcmw_pkg::t_cfg    cfg;
    tcmw_pkg::t_item   in_item;
    tcmw_pkg::t_item   held_item;
    tcmw_pkg::t_result cur_res;
    tcmw_pkg::t_result out_res;
    logic              held_valid;
    logic              take;

    assign in_item.ch          = i_ch;
    assign in_item.first       = i_first;
    assign in_item.append_line = i_append_line;
    assign in_item.start_col   = i_start_col;
    assign in_item.start_row   = i_start_row;

    tcmw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tcmw_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_stall (o_in_stall),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    tcmw_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (take),
        .i_item  (held_item),
        .i_cfg   (cfg),
        .o_res   (cur_res)
    );

    tcmw_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (held_valid),
        .i_res   (cur_res),
        .o_take  (take),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_write_en    = out_res.write_en;
    assign o_cell_index  = out_res.cell_index;
    assign o_cell_char   = out_res.cell_char;
    assign o_cell_fg     = out_res.cell_fg;
    assign o_cell_bg     = out_res.cell_bg;
    assign o_string_done = out_res.string_done;

    `TCMW_ASSERT(a_index_in_grid, o_out_valid && o_write_en |-> 32'(o_cell_index) < tcmw_pkg::CELLS, "cell index beyond the buffer")
    `TCMW_NEVER(a_write_and_done, o_out_valid && o_write_en && o_string_done, "write and string end in one word")
    `TCMW_ASSERT(a_write_char, o_out_valid && o_write_en |-> o_cell_char != tcmw_pkg::CH_NUL && o_cell_char != tcmw_pkg::CH_LBR && o_cell_char != tcmw_pkg::CH_RBR, "control character written to a cell")
    `TCMW_ASSERT(a_stall_full, o_in_stall |-> held_valid && !take, "input stalled while its register can move")

endmodule
`default_nettype wire

// File: tb/tb_text_cell_markup_writer.sv
// Testbench for text_cell_markup_writer: directed and random strings are driven through
// several register settings and idle patterns, and every result word is checked.
// Depends on tcmw_pkg and the text_cell_markup_writer RTL only.
import tcmw_pkg::*;

// Tracks the cursor, brackets and line counter of the writer and keeps the
// expected result word for every accepted character word.
class cell_write_board;
    t_cfg        cfg;
    logic [7:0]  cur_row;
    logic [7:0]  cur_col;
    logic [7:0]  home_col;
    logic [7:0]  line_ctr;
    logic        special_on;
    logic        accepting;
    logic        append_active;
    t_result     pending_writes[$];
    int          mismatches;

    function new();
        cfg.columns    = COLUMNS_RST;
        cfg.rows       = ROWS_RST;
        cfg.normal_fg  = '0;
        cfg.special_fg = '0;
        cfg.normal_bg  = '0;
        cur_row        = '0;
        cur_col        = '0;
        home_col       = '0;
        line_ctr       = '0;
        special_on     = 1'b0;
        accepting      = 1'b0;
        append_active  = 1'b0;
        mismatches     = 0;
    endfunction

    function void set_reg(t_reg_idx r, logic [15:0] v);
        case (r)
            REG_COLUMNS: begin
                cfg.columns = v[7:0];
            end
            REG_ROWS: begin
                cfg.rows = v[7:0];
            end
            REG_NORMAL_FG: begin
                cfg.normal_fg = v;
            end
            REG_SPECIAL_FG: begin
                cfg.special_fg = v;
            end
            REG_NORMAL_BG: begin
                cfg.normal_bg = v;
            end
            default: begin
            end
        endcase
    endfunction

    // The row counter saturates at the number of rows in use.
    function void advance_row();
        if (cur_row < cfg.rows) begin
            cur_row = cur_row + 8'd1;
        end
    endfunction

    function void take_char(t_item it);
        t_result r;
        int      idx;
        r = '0;
        if (it.first) begin
            special_on = 1'b0;
            if (it.append_line) begin
                accepting     = 1'b1;
                append_active = 1'b1;
                cur_row       = line_ctr;
                cur_col       = '0;
                home_col      = '0;
            end else if (it.start_col < cfg.columns && it.start_row < cfg.rows) begin
                accepting     = 1'b1;
                append_active = 1'b0;
                cur_row       = it.start_row;
                cur_col       = it.start_col;
                home_col      = it.start_col;
            end else begin
                accepting     = 1'b0;
                append_active = 1'b0;
            end
        end
        if (accepting) begin
            if (it.ch == CH_NUL) begin
                r.string_done = 1'b1;
                if (append_active) begin
                    line_ctr = line_ctr + 8'd1;
                    if (line_ctr >= cfg.rows) begin
                        line_ctr = '0;
                    end
                end
                accepting     = 1'b0;
                append_active = 1'b0;
            end else begin
                // A column left past the row end by a narrower setting wraps first.
                if (cur_col >= cfg.columns) begin
                    cur_col = '0;
                    advance_row();
                end
                idx = int'(cur_row) * int'(cfg.columns) + int'(cur_col);
                if (cur_row < cfg.rows && idx < CELLS) begin
                    if (it.ch == CH_CR || it.ch == CH_LF) begin
                        advance_row();
                        cur_col = home_col;
                    end else if (it.ch == CH_LBR || it.ch == CH_RBR) begin
                        special_on = (it.ch == CH_LBR);
                    end else begin
                        r.write_en   = 1'b1;
                        r.cell_index = idx[7:0];
                        r.cell_char  = it.ch;
                        r.cell_fg    = special_on ? cfg.special_fg : cfg.normal_fg;
                        r.cell_bg    = cfg.normal_bg;
                        cur_col      = cur_col + 8'd1;
                        if (cur_col >= cfg.columns) begin
                            cur_col = '0;
                            advance_row();
                        end
                    end
                end
            end
        end
        pending_writes.push_back(r);
    endfunction

    function void note_failure(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function void match_write(t_result got);
        t_result want;
        if (pending_writes.size() == 0) begin
            note_failure($sformatf("result word with nothing expected: %p", got));
        end else begin
            want = pending_writes.pop_front();
            if (got.write_en !== want.write_en || got.cell_index !== want.cell_index ||
                got.cell_char !== want.cell_char || got.cell_fg !== want.cell_fg ||
                got.cell_bg !== want.cell_bg || got.string_done !== want.string_done) begin
                note_failure($sformatf("mismatch: expected %p, got %p", want, got));
            end
        end
    endfunction
endclass

module tb_text_cell_markup_writer;
    localparam int CYCLE_LIMIT = 400000;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [7:0]          i_ch;
    logic                i_first;
    logic                i_append_line;
    logic [7:0]          i_start_col;
    logic [7:0]          i_start_row;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_write_en;
    logic [7:0]          o_cell_index;
    logic [7:0]          o_cell_char;
    logic [15:0]         o_cell_fg;
    logic [15:0]         o_cell_bg;
    logic                o_string_done;

    cell_write_board     board;
    int                  gap_pct;
    int                  stall_pct;
    int                  sent_items;
    int                  cycles;

    text_cell_markup_writer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_ch          (i_ch),
        .i_first       (i_first),
        .i_append_line (i_append_line),
        .i_start_col   (i_start_col),
        .i_start_row   (i_start_row),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_write_en    (o_write_en),
        .o_cell_index  (o_cell_index),
        .o_cell_char   (o_cell_char),
        .o_cell_fg     (o_cell_fg),
        .o_cell_bg     (o_cell_bg),
        .o_string_done (o_string_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Input words are noted before result words are checked, so a combinational
    // path would still find its expectation waiting.
    always @(posedge i_clk) begin : watch
        t_item   seen;
        t_result got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_text_cell_markup_writer: errors");
            $finish;
        end
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                seen.ch          = i_ch;
                seen.first       = i_first;
                seen.append_line = i_append_line;
                seen.start_col   = i_start_col;
                seen.start_row   = i_start_row;
                board.take_char(seen);
            end
            if (o_out_valid && !i_out_stall) begin
                got.write_en    = o_write_en;
                got.cell_index  = o_cell_index;
                got.cell_char   = o_cell_char;
                got.cell_fg     = o_cell_fg;
                got.cell_bg     = o_cell_bg;
                got.string_done = o_string_done;
                board.match_write(got);
            end
        end
    end

    task automatic write_reg(input t_reg_idx r, input logic [15:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(r));
        pwdata  <= {16'h0000, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(r, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input logic [7:0] cols, input logic [7:0] rws,
                               input logic [15:0] nfg, input logic [15:0] sfg,
                               input logic [15:0] bg);
        write_reg(REG_COLUMNS, {8'h00, cols});
        write_reg(REG_ROWS, {8'h00, rws});
        write_reg(REG_NORMAL_FG, nfg);
        write_reg(REG_SPECIAL_FG, sfg);
        write_reg(REG_NORMAL_BG, bg);
    endtask

    // Presents one character word and returns at the edge that accepts it.
    task automatic send_char(input t_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_ch          <= it.ch;
        i_first       <= it.first;
        i_append_line <= it.append_line;
        i_start_col   <= it.start_col;
        i_start_row   <= it.start_row;
        do @(posedge i_clk); while (o_in_stall);
        sent_items++;
    endtask

    task automatic put(input logic [7:0] ch, input logic first, input logic app,
                       input logic [7:0] col, input logic [7:0] row);
        t_item it;
        it.ch          = ch;
        it.first       = first;
        it.append_line = app;
        it.start_col   = col;
        it.start_row   = row;
        send_char(it);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = $urandom_range(0, 1) ? CH_LBR : CH_RBR;
            1: c = $urandom_range(0, 1) ? CH_CR : CH_LF;
            2: c = 8'($urandom_range(1, 255));
            default: c = 8'($urandom_range(32, 126));
        endcase
        return c;
    endfunction

    // Mostly whole strings with random content; the rest is loose words and
    // strings that never get their terminating zero.
    task automatic send_random_string();
        t_item it;
        int    len;
        bit    broken;
        if ($urandom_range(0, 99) < 20) begin
            it           = t_item'($urandom());
            it.ch        = ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom());
            it.start_col = 8'($urandom());
            it.start_row = 8'($urandom());
            send_char(it);
        end else begin
            len    = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 170)
                                                  : $urandom_range(0, 12);
            broken = ($urandom_range(0, 9) == 0);
            for (int k = 0; k <= len; k++) begin
                if (!(k == len && broken)) begin
                    it.first       = (k == 0);
                    it.append_line = ($urandom_range(0, 99) < 40);
                    if (k == 0 && $urandom_range(0, 99) < 80) begin
                        it.start_col = 8'($urandom_range(0, int'(board.cfg.columns) - 1));
                        it.start_row = 8'($urandom_range(0, int'(board.cfg.rows) - 1));
                    end else begin
                        it.start_col = 8'($urandom());
                        it.start_row = 8'($urandom());
                    end
                    it.ch = (k < len) ? pick_char() : CH_NUL;
                    send_char(it);
                end
            end
        end
    endtask

    task automatic run_random(input int n, input int send_pct, input int recv_pct);
        int target;
        gap_pct   = send_pct;
        stall_pct = recv_pct;
        target    = sent_items + n;
        while (sent_items < target) begin
            send_random_string();
        end
    endtask

    // Waits for every expected word and then idles before the registers may
    // change.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending_writes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] cols;
        board         = new();
        cycles        = 0;
        sent_items    = 0;
        gap_pct       = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_ch          = '0;
        i_first       = 1'b0;
        i_append_line = 1'b0;
        i_start_col   = '0;
        i_start_row   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        load_config(8'd16, 8'd10, 16'hFFFF, 16'h0000, 16'hFFFF);
        // A character with no string open is dropped.
        put("A", 1'b0, 1'b0, 8'd0, 8'd0);
        // Placed string with brackets, both line breaks and a high code.
        put("A", 1'b1, 1'b0, 8'd0, 8'd0);
        put(CH_LBR, 1'b0, 1'b0, 8'd0, 8'd0);
        put("B", 1'b0, 1'b0, 8'd0, 8'd0);
        put(CH_RBR, 1'b0, 1'b0, 8'd0, 8'd0);
        put("C", 1'b0, 1'b0, 8'd0, 8'd0);
        put(CH_CR, 1'b0, 1'b0, 8'd0, 8'd0);
        put("D", 1'b0, 1'b0, 8'd0, 8'd0);
        put(CH_LF, 1'b0, 1'b0, 8'd0, 8'd0);
        put(8'hFF, 1'b0, 1'b0, 8'd0, 8'd0);
        put(CH_NUL, 1'b0, 1'b0, 8'd0, 8'd0);
        // Starts outside the grid ignore the whole string.
        put("x", 1'b1, 1'b0, 8'd16, 8'd0);
        put(CH_NUL, 1'b0, 1'b0, 8'd0, 8'd0);
        put("x", 1'b1, 1'b0, 8'd0, 8'd10);
        put("y", 1'b1, 1'b0, 8'd255, 8'd255);
        put(CH_NUL, 1'b0, 1'b0, 8'd0, 8'd0);
        // An append string cut off by a placed one in the last cell, which
        // then runs off the end of the grid.
        put("a", 1'b1, 1'b1, 8'd0, 8'd0);
        put("b", 1'b0, 1'b0, 8'd0, 8'd0);
        put("z", 1'b1, 1'b0, 8'd15, 8'd9);
        put("y", 1'b0, 1'b0, 8'd0, 8'd0);
        put(CH_NUL, 1'b0, 1'b0, 8'd0, 8'd0);
        // Empty append string, then a bracketed one on the next line.
        put(CH_NUL, 1'b1, 1'b1, 8'd0, 8'd0);
        put(CH_LBR, 1'b1, 1'b1, 8'd0, 8'd0);
        put("Q", 1'b0, 1'b0, 8'd0, 8'd0);
        put(CH_NUL, 1'b0, 1'b0, 8'd0, 8'd0);
        run_random(125, 0, 0);
        settle();

        load_config(8'd1, 8'd160, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        run_random(150, 52, 0);
        settle();

        load_config(8'd160, 8'd1, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        run_random(150, 0, 52);
        settle();

        // More cells than the buffer holds: writes stop at the buffer end.
        load_config(8'd20, 8'd10, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        run_random(150, 19, 19);
        settle();

        load_config(8'd160, 8'd160, 16'h0000, 16'hFFFF, 16'h0000);
        run_random(150, 0, 0);
        settle();

        cols = 8'($urandom_range(1, 160));
        load_config(cols, 8'($urandom_range(1, 160 / int'(cols))),
                    16'($urandom()), 16'($urandom()), 16'($urandom()));
        run_random(150, 19, 19);
        settle();

        repeat (8) @(posedge i_clk);
        if (board.pending_writes.size() != 0) begin
            board.note_failure($sformatf("%0d result words never arrived",
                                         board.pending_writes.size()));
        end
        if (board.mismatches == 0) begin
            $display("tb_text_cell_markup_writer: clean");
        end else begin
            $display("tb_text_cell_markup_writer: errors");
        end
        $finish;
    end
endmodule
